[rtl/core/tkh_pkg.sv]
// Shared widths, entry type and defaults for the top-K min-heap block.
package tkh_pkg;

   localparam int KEY_W        = 32;
   localparam int TAG_W        = 16;
   localparam int LIMIT_W      = 6;
   localparam int DEF_CAPACITY = 32;

   // Operation codes of an input beat
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // One heap slot: ordering key and the tag carried with it
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

[rtl/core/tkh_store.sv]
// Heap slot memory: one write port and one registered read port.
module tkh_store #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  tkh_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output tkh_pkg::entry_type rd_data
);
   import tkh_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write one slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read slot
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/top_k_min_heap.sv]
// Top level: bounded min-heap keeping the K largest keyed items, with sorted flush.
//
//   channel   ports                                   direction
//   req       req_valid/ready, req_op/key/tag         in   (add or flush beat)
//   rsp       rsp_valid/ready, rsp_key_out/tag_out,   out  (one beat per flushed entry)
//             rsp_last
//   csr       csr_valid/ready, csr_heap_limit         in   (heap_limit write)
//
// One sequencer drives a single heap memory port pair and one key comparator.
// Add: sift-up reads the parent and compares it (UP_CHK, UP_CMP) on each level;
//   a replace at the root reads and compares the root, then sifts down level by level.
// Flush: an in-place heapsort moves each root behind the shrinking heap and sifts down,
//   then each output beat reads a slot and emits it, holding on output stalls.
// Reset clears the entry count, the limit and the sequencer; slots need no clearing.
// req_ready is high only while the sequencer is idle; a stalled rsp beat holds the emit.
module top_k_min_heap #(
   parameter int CAPACITY = tkh_pkg::DEF_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [tkh_pkg::KEY_W-1:0]    req_key,
   input  logic [tkh_pkg::TAG_W-1:0]    req_tag,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tkh_pkg::KEY_W-1:0]    rsp_key_out,
   output logic [tkh_pkg::TAG_W-1:0]    rsp_tag_out,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tkh_pkg::LIMIT_W-1:0]  csr_heap_limit
);
   import tkh_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PTR_W = $clog2(2 * CAPACITY + 1);

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_UP_CHK   = 14'b00000000000010,
      S_UP_CMP   = 14'b00000000000100,
      S_ROOT_RD  = 14'b00000000001000,
      S_ROOT_CMP = 14'b00000000010000,
      S_DN_RDL   = 14'b00000000100000,
      S_DN_RDR   = 14'b00000001000000,
      S_DN_CMP   = 14'b00000010000000,
      S_DN_MOV   = 14'b00000100000000,
      S_FL_NEXT  = 14'b00001000000000,
      S_FL_RD0   = 14'b00010000000000,
      S_FL_WRN   = 14'b00100000000000,
      S_EM_RD    = 14'b01000000000000,
      S_EM_OUT   = 14'b10000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [PTR_W-1:0]      i_ff, i_in;
   logic                  flushing_ff, flushing_in;
   entry_type             item_ff, item_in;
   entry_type             left_ff, left_in;
   logic                  pick_r_ff, pick_r_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   entry_type             rsp_data_ff, rsp_data_in;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   entry_type             mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   entry_type             mem_rd_data;

   logic [CNT_W-1:0]      lim;
   logic [PTR_W-1:0]      n_ext;
   logic [PTR_W-1:0]      parent;
   logic [PTR_W-1:0]      child_l;
   logic [PTR_W-1:0]      child_r;
   logic                  right_ok;
   logic [KEY_W-1:0]      cmp_a;
   logic [KEY_W-1:0]      cmp_b;
   logic                  cmp_le;
   logic                  out_free;
   state_type             done_state;

   tkh_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Saturate the limit at the capacity
   assign lim = (limit_ff >= CAPACITY) ? CNT_W'(CAPACITY) : CNT_W'(limit_ff);

   // Tree links of the current slot
   assign n_ext    = PTR_W'(n_ff);
   assign parent   = (i_ff - PTR_W'(1)) >> 1;
   assign child_l  = PTR_W'({i_ff, 1'b1});
   assign child_r  = child_l + PTR_W'(1);
   assign right_ok = child_r < n_ext;

   // Shared key comparator
   assign cmp_le = cmp_a <= cmp_b;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign done_state = flushing_ff ? S_FL_NEXT : S_IDLE;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key_out = rsp_data_ff.key;
   assign rsp_tag_out = rsp_data_ff.tag;
   assign rsp_last    = rsp_last_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      flushing_in  = flushing_ff;
      item_in      = item_ff;
      left_in      = left_ff;
      pick_r_in    = pick_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = i_ff[IDX_W-1:0];
      mem_wr_data  = item_ff;
      mem_rd_addr  = '0;
      cmp_a        = item_ff.key;
      cmp_b        = mem_rd_data.key;

      if (csr_valid) begin
         limit_in = csr_heap_limit;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in.key = req_key;
               item_in.tag = req_tag;
               if (req_op == OP_FLUSH) begin
                  flushing_in = 1'b1;
                  n_in        = count_ff;
                  state_in    = S_FL_NEXT;
               end else if (lim == '0) begin
                  state_in = S_IDLE;
               end else if (count_ff >= lim) begin
                  state_in = S_ROOT_RD;
               end else begin
                  i_in     = PTR_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_UP_CHK;
               end
            end
         end
         // Sift up: fetch the parent or place at the root
         S_UP_CHK: begin
            mem_rd_addr = parent[IDX_W-1:0];
            if (i_ff == '0) begin
               mem_wr_en = 1'b1;
               state_in  = S_IDLE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_wr_en = 1'b1;
            cmp_a     = mem_rd_data.key;
            cmp_b     = item_ff.key;
            if (cmp_le) begin
               state_in = S_IDLE;
            end else begin
               mem_wr_data = mem_rd_data;
               i_in        = parent;
               state_in    = S_UP_CHK;
            end
         end
         // Full heap: compare against the root
         S_ROOT_RD: begin
            mem_rd_addr = '0;
            state_in    = S_ROOT_CMP;
         end
         S_ROOT_CMP: begin
            if (cmp_le) begin
               state_in = S_IDLE;
            end else begin
               n_in     = count_ff;
               i_in     = '0;
               state_in = S_DN_RDL;
            end
         end
         // Sift down: fetch left child or place the item
         S_DN_RDL: begin
            mem_rd_addr = child_l[IDX_W-1:0];
            if (child_l >= n_ext) begin
               mem_wr_en = 1'b1;
               state_in  = done_state;
            end else begin
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            left_in     = mem_rd_data;
            mem_rd_addr = right_ok ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
            state_in    = S_DN_CMP;
         end
         // Pick the lesser child; the right one only when strictly less
         S_DN_CMP: begin
            cmp_a     = left_ff.key;
            cmp_b     = mem_rd_data.key;
            pick_r_in = right_ok && !cmp_le;
            if (right_ok && !cmp_le) begin
               left_in = mem_rd_data;
            end
            state_in = S_DN_MOV;
         end
         // Place the item or move the chosen child up
         S_DN_MOV: begin
            mem_wr_en = 1'b1;
            cmp_a     = item_ff.key;
            cmp_b     = left_ff.key;
            if (cmp_le) begin
               state_in = done_state;
            end else begin
               mem_wr_data = left_ff;
               i_in        = pick_r_ff ? child_r : child_l;
               state_in    = S_DN_RDL;
            end
         end
         // Heapsort: move the root behind the shrinking heap
         S_FL_NEXT: begin
            mem_rd_addr = IDX_W'(n_ff - CNT_W'(1));
            if (n_ff == '0) begin
               j_in = '0;
               if (count_ff == '0) begin
                  flushing_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_EM_RD;
               end
            end else begin
               n_in     = n_ff - CNT_W'(1);
               state_in = S_FL_RD0;
            end
         end
         S_FL_RD0: begin
            item_in     = mem_rd_data;
            mem_rd_addr = '0;
            state_in    = S_FL_WRN;
         end
         S_FL_WRN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = IDX_W'(n_ff);
            mem_wr_data = mem_rd_data;
            i_in        = '0;
            state_in    = S_DN_RDL;
         end
         // Emit slots in order, largest first
         S_EM_RD: begin
            mem_rd_addr = IDX_W'(j_ff);
            state_in    = S_EM_OUT;
         end
         S_EM_OUT: begin
            mem_rd_addr = IDX_W'(j_ff);
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mem_rd_data;
               rsp_last_in  = (j_ff + CNT_W'(1)) == count_ff;
               j_in         = j_ff + CNT_W'(1);
               if ((j_ff + CNT_W'(1)) == count_ff) begin
                  count_in    = '0;
                  flushing_in = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_EM_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         count_ff     <= '0;
         flushing_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         flushing_ff  <= flushing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      j_ff        <= j_in;
      i_ff        <= i_in;
      item_ff     <= item_in;
      left_ff     <= left_in;
      pick_r_ff   <= pick_r_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[bench/top_k_min_heap_tb.sv]
// Self-checking testbench for top_k_min_heap: a heap predictor, random traffic and a stall pattern.
`timescale 1ns / 1ps

module top_k_min_heap_tb;
   import tkh_pkg::*;

   localparam int          CAP        = DEF_CAPACITY;
   localparam int          IDLE_GAP   = 40;
   localparam int          LONG_HOLD  = 600;
   localparam int          RAND_ITEMS = 110;
   localparam int unsigned WATCHDOG   = 400000;

   // One expected output beat of a flush
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic             last;
   } flush_beat_type;

   // Predict heap contents and hold the entries a flush will emit
   class top_k_tracker;
      entry_type           slots [CAP];
      int unsigned         count;
      logic [LIMIT_W-1:0]  limit;
      flush_beat_type      flushed_entries [$];
      int                  errors;

      function new();
         count  = 0;
         limit  = '0;
         errors = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int pending();
         return flushed_entries.size();
      endfunction

      // Move item down from the root over the first n slots
      function void sift_down(entry_type item, int unsigned n);
         int unsigned i;
         int unsigned c;
         i = 0;
         forever begin
            c = 2 * i + 1;
            if (c >= n) break;
            if (c + 1 < n && slots[c + 1].key < slots[c].key) c = c + 1;
            if (item.key <= slots[c].key) break;
            slots[i] = slots[c];
            i = c;
         end
         slots[i] = item;
      endfunction

      function void insert(entry_type item);
         int unsigned kept;
         int unsigned i;
         int unsigned p;
         kept = (limit > CAP) ? CAP : limit;
         if (kept == 0) return;
         // Full heap: drop anything not above the root, else replace the root
         if (count >= kept) begin
            if (item.key <= slots[0].key) return;
            sift_down(item, count);
            return;
         end
         i = count;
         count++;
         while (i != 0) begin
            p = (i - 1) / 2;
            if (slots[p].key <= item.key) break;
            slots[i] = slots[p];
            i = p;
         end
         slots[i] = item;
      endfunction

      // Heapsort in place, queue the sorted entries, empty the heap
      function void sort_out();
         int unsigned    n;
         entry_type      moved;
         flush_beat_type b;
         n = count;
         while (n > 0) begin
            n--;
            moved    = slots[n];
            slots[n] = slots[0];
            sift_down(moved, n);
         end
         for (int unsigned j = 0; j < count; j++) begin
            b.key  = slots[j].key;
            b.tag  = slots[j].tag;
            b.last = (j + 1 == count);
            flushed_entries.push_back(b);
         end
         count = 0;
      endfunction

      function void note_request(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
         entry_type e;
         if (op == OP_FLUSH) begin
            sort_out();
         end else begin
            e.key = key;
            e.tag = tag;
            insert(e);
         end
      endfunction

      function void check_beat(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
         flush_beat_type b;
         if (flushed_entries.size() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat: expected none, got key %h tag %h last %b",
                     $time, key, tag, last);
            return;
         end
         b = flushed_entries.pop_front();
         if (key !== b.key) begin
            errors++;
            $display("%0t: key_out mismatch: expected %h, got %h", $time, b.key, key);
         end
         if (tag !== b.tag) begin
            errors++;
            $display("%0t: tag_out mismatch: expected %h, got %h", $time, b.tag, tag);
         end
         if (last !== b.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, got %b", $time, b.last, last);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = OP_ADD;
   logic [KEY_W-1:0]   req_key = '0;
   logic [TAG_W-1:0]   req_tag = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [KEY_W-1:0]   rsp_key_out;
   logic [TAG_W-1:0]   rsp_tag_out;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_heap_limit = '0;

   top_k_tracker sb = new();
   int unsigned  cycles = 0;
   int unsigned  holds_asked = 0;
   int unsigned  holds_served = 0;
   int           burst_left = 0;
   int           sent = 0;

   top_k_min_heap dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_tag        (req_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_out    (rsp_key_out),
      .rsp_tag_out    (rsp_tag_out),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_heap_limit (csr_heap_limit)
   );

   always #5 clock = ~clock;

   // Check every accepted rsp beat against the oldest flushed entry
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_key_out, rsp_tag_out, rsp_last);
   end

   // Stall rsp on a run-length pattern; serve long hold-offs on request
   initial begin : rsp_pacer
      int  run;
      logic level;
      forever begin
         if (holds_asked != holds_served) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_served++;
         end else begin
            case ($urandom_range(0, 9))
               0:       begin run = $urandom_range(40, 80); level = 1'b1; end
               1, 2, 3: begin run = $urandom_range(1, 12);  level = 1'b0; end
               default: begin run = $urandom_range(1, 10);  level = 1'b1; end
            endcase
            repeat (run) begin
               @(negedge clock);
               rsp_ready <= level;
            end
         end
      end
   end

   // Stop a hung run
   initial begin : watchdog
      while (cycles < WATCHDOG) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom_range(0, 15);
         5:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [TAG_W-1:0] pick_tag();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return TAG_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Offer one req beat and hold it until accepted
   task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      req_tag   <= tag;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sb.note_request(op, key, tag);
   endtask

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Drop valid, wait for every flushed entry, then let the sequencer finish
   task automatic settle();
      idle_req(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      settle();
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_heap_limit <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Insert idle gaps between bursts of random length
   task automatic pace();
      if (burst_left == 0) begin
         idle_req($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LIMIT_W'(1);
         2:       return LIMIT_W'(CAP);
         3:       return '1;
         4:       return LIMIT_W'($urandom_range(CAP + 1, 62));
         default: return LIMIT_W'($urandom_range(2, CAP - 1));
      endcase
   endfunction

   initial begin : stimulus
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Limit zero after reset: adds are ignored, flush of an empty heap
      send_item(OP_ADD, 32'h0000_1234, 16'h0001);
      send_item(OP_FLUSH, '0, '0);

      // Small heap: extremes, ties, replace at root, drops at and below root
      write_limit(LIMIT_W'(4));
      send_item(OP_ADD, '1, '1);
      send_item(OP_ADD, '0, '0);
      send_item(OP_ADD, 32'd5, 16'hA5A5);
      send_item(OP_ADD, 32'd5, 16'h5A5A);
      send_item(OP_ADD, 32'd5, 16'h0F0F);
      send_item(OP_ADD, '0, 16'h1111);
      send_item(OP_ADD, 32'd3, 16'h2222);
      send_item(OP_ADD, 32'd5, 16'h3333);
      send_item(OP_ADD, 32'hFFFF_FFFE, 16'h8000);
      send_item(OP_FLUSH, '1, '1);
      send_item(OP_FLUSH, 32'h5555_AAAA, 16'hC3C3);

      // Lower the limit below the count, then disable adds, then flush all
      write_limit(LIMIT_W'(CAP));
      send_item(OP_ADD, 32'd9, 16'h0009);
      send_item(OP_ADD, 32'd7, 16'h0007);
      send_item(OP_ADD, 32'd8, 16'h0008);
      send_item(OP_ADD, 32'd1, 16'h0001);
      send_item(OP_ADD, 32'd6, 16'h0006);
      send_item(OP_ADD, 32'd2, 16'h0002);
      write_limit(LIMIT_W'(2));
      send_item(OP_ADD, '1, 16'h1357);
      send_item(OP_ADD, 32'd1, 16'h2468);
      write_limit('0);
      send_item(OP_ADD, '1, 16'hBEEF);
      send_item(OP_FLUSH, '0, '0);

      // Limit above capacity saturates
      write_limit('1);
      send_item(OP_ADD, 32'h8000_0000, 16'h4000);
      send_item(OP_ADD, 32'h7FFF_FFFF, 16'h7FFF);
      send_item(OP_FLUSH, '0, '0);

      // Hold off rsp during a flush while more adds are offered
      write_limit(LIMIT_W'(CAP));
      repeat (20) send_item(OP_ADD, pick_key(), pick_tag());
      holds_asked++;
      send_item(OP_FLUSH, $urandom, pick_tag());
      repeat (4) send_item(OP_ADD, pick_key(), pick_tag());
      send_item(OP_FLUSH, $urandom, pick_tag());
      settle();

      // Random phases, each at its own limit
      while (sent < RAND_ITEMS) begin
         write_limit(pick_limit());
         n = $urandom_range(8, 45);
         repeat (n) begin
            pace();
            if ($urandom_range(0, 9) == 0) send_item(OP_FLUSH, $urandom, pick_tag());
            else send_item(OP_ADD, pick_key(), pick_tag());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) send_item(OP_FLUSH, $urandom, pick_tag());
      end
      send_item(OP_FLUSH, '0, '0);

      settle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tkh_pkg.sv
rtl/core/tkh_store.sv
rtl/core/top_k_min_heap.sv
bench/top_k_min_heap_tb.sv
